// ----- rtl/core/dal_pkg.sv -----
// Types and constants shared by the daily actuation lockout gate.
package dal_pkg;

    // Request kinds
    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_SPRAY = 1'b1;

    // Verdict codes
    localparam logic [2:0] V_QUERY   = 3'd0;
    localparam logic [2:0] V_GRANTED = 3'd1;
    localparam logic [2:0] V_SENSOR  = 3'd2;
    localparam logic [2:0] V_SOIL    = 3'd3;
    localparam logic [2:0] V_BATTERY = 3'd4;
    localparam logic [2:0] V_LIMIT   = 3'd5;
    localparam logic [2:0] V_SOON    = 3'd6;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_DAY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_MINUTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_MIN_MV  = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [7:0]  RST_MAX_PER_DAY     = 8'd3;
    localparam logic [15:0] RST_MIN_GAP_MINUTES = 16'd60;
    localparam logic [15:0] RST_BATTERY_MIN_MV  = 16'd3300;

    // Reciprocals: x / 86400 = ((x >> 7) * DAY_RECIP) >> DAY_SHIFT for 32-bit x,
    // x / 60 = (x * MIN_RECIP) >> MIN_SHIFT for 32-bit x.
    localparam logic [25:0] DAY_RECIP = 26'd50903317;
    localparam int unsigned DAY_SHIFT = 35;
    localparam logic [31:0] MIN_RECIP = 32'h8888_8889;
    localparam int unsigned MIN_SHIFT = 37;

    typedef struct packed {
        logic        req_type;
        logic [31:0] now_seconds;
        logic        sensor_err;
        logic        soil_ok;
        logic [15:0] battery_mv;
    } t_dal_in;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [7:0]  count_today;
        logic [31:0] minutes_since;
    } t_dal_out;

endpackage

// ----- rtl/core/daily_actuation_lockout.sv -----
// Daily actuation lockout gate: day roll-over, refusal checks and grant bookkeeping.
// Pipeline: three register stages; an accepted item's result is held in the last
// stage until it leaves at an edge where the output is not stalled.
// Throughput: one item per cycle while the output is not stalled; the day divide, the
// gate decision and the minute divide each take one register stage of a three-stage pipeline.
// Reset (synchronous, active low) clears the pipeline, the day, count and grant
// history, and loads the default limit, gap and battery threshold.
module daily_actuation_lockout
    import dal_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_dal_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_dal_out              o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration
    logic [7:0]  r_max_per_day;
    logic [15:0] r_min_gap_minutes;
    logic [15:0] r_battery_min_mv;

    // Gate state
    logic [15:0] r_day_index,  n_day_index;
    logic [7:0]  r_grants,     n_grants;
    logic        r_has_granted, n_has_granted;
    logic [31:0] r_last_grant, n_last_grant;

    // Stage 1: item and its day number
    logic        r_v1;
    t_dal_in     r_s1_item;
    logic [15:0] r_s1_day;
    logic [50:0] day_prod;

    // Stage 2: verdict, count and the raw time difference
    logic        r_v2;
    logic [2:0]  r_s2_verdict, n_s2_verdict;
    logic [7:0]  r_s2_count,   n_s2_count;
    logic        r_s2_never,   n_s2_never;
    logic        r_s2_behind,  n_s2_behind;
    logic [31:0] r_s2_diff,    n_s2_diff;

    // Stage 3: result register
    logic        r_v3;
    t_dal_out    r_out;
    logic [63:0] min_prod;
    logic [31:0] n_minutes;

    logic free3, free2, free1, mv1;

    // Decision helpers
    logic [7:0]  eff_count;
    logic [21:0] gap_seconds;
    logic [32:0] gap_diff;
    logic        gap_ok;
    logic        grant;
    logic [32:0] post_diff;

    // Handshake: each stage loads when it is empty or its successor has room
    assign free3       = !r_v3 || !i_out_stall;
    assign free2       = !r_v2 || free3;
    assign free1       = !r_v1 || free2;
    assign mv1         = r_v1 && free2;
    assign o_in_stall  = !free1;
    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign day_prod = {1'b0, i_in_data.now_seconds[31:7]} * {25'd0, DAY_RECIP};

    always_comb begin
        eff_count   = (r_day_index == r_s1_day) ? r_grants : 8'd0;
        // minutes >= gap  <=>  seconds >= gap * 60
        gap_seconds = ({r_min_gap_minutes, 6'd0}) - ({4'd0, r_min_gap_minutes, 2'd0});
        gap_diff    = {1'b0, r_s1_item.now_seconds} - {1'b0, r_last_grant};
        gap_ok      = !r_has_granted || (r_min_gap_minutes == 16'd0) ||
                      (!gap_diff[32] && (gap_diff[31:0] >= {10'd0, gap_seconds}));

        grant = 1'b0;
        if (r_s1_item.req_type == REQ_QUERY) begin
            n_s2_verdict = V_QUERY;
        end else if (r_s1_item.sensor_err) begin
            n_s2_verdict = V_SENSOR;
        end else if (!r_s1_item.soil_ok) begin
            n_s2_verdict = V_SOIL;
        end else if (r_s1_item.battery_mv < r_battery_min_mv) begin
            n_s2_verdict = V_BATTERY;
        end else if (eff_count >= r_max_per_day) begin
            n_s2_verdict = V_LIMIT;
        end else if (!gap_ok) begin
            n_s2_verdict = V_SOON;
        end else begin
            n_s2_verdict = V_GRANTED;
            grant        = 1'b1;
        end

        n_day_index   = r_s1_day;
        n_grants      = grant ? eff_count + 8'd1 : eff_count;
        n_has_granted = r_has_granted || grant;
        n_last_grant  = grant ? r_s1_item.now_seconds : r_last_grant;

        post_diff   = {1'b0, r_s1_item.now_seconds} - {1'b0, n_last_grant};
        n_s2_count  = n_grants;
        n_s2_never  = !n_has_granted;
        n_s2_behind = post_diff[32];
        n_s2_diff   = post_diff[31:0];
    end

    assign min_prod = {32'd0, r_s2_diff} * {32'd0, MIN_RECIP};

    always_comb begin
        if (r_s2_never) begin
            n_minutes = '1;
        end else if (r_s2_behind) begin
            n_minutes = '0;
        end else begin
            n_minutes = {5'd0, min_prod[63:MIN_SHIFT]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_per_day     <= RST_MAX_PER_DAY;
            r_min_gap_minutes <= RST_MIN_GAP_MINUTES;
            r_battery_min_mv  <= RST_BATTERY_MIN_MV;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_PER_DAY:     r_max_per_day     <= i_cfg_data[7:0];
                CFG_MIN_GAP_MINUTES: r_min_gap_minutes <= i_cfg_data;
                CFG_BATTERY_MIN_MV:  r_battery_min_mv  <= i_cfg_data;
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // Commit gate state once per item, as it leaves stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day_index   <= '0;
            r_grants      <= '0;
            r_has_granted <= 1'b0;
            r_last_grant  <= '0;
        end else if (mv1) begin
            r_day_index   <= n_day_index;
            r_grants      <= n_grants;
            r_has_granted <= n_has_granted;
            r_last_grant  <= n_last_grant;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_in_valid;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_s1_item <= i_in_data;
            r_s1_day  <= day_prod[50:DAY_SHIFT];
        end
        if (free2) begin
            r_s2_verdict <= n_s2_verdict;
            r_s2_count   <= n_s2_count;
            r_s2_never   <= n_s2_never;
            r_s2_behind  <= n_s2_behind;
            r_s2_diff    <= n_s2_diff;
        end
        if (free3) begin
            r_out.verdict       <= r_s2_verdict;
            r_out.count_today   <= r_s2_count;
            r_out.minutes_since <= n_minutes;
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench for the daily actuation lockout gate: directed, configuration and random checks.
`timescale 1ns / 100ps

module tb;
    import dal_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned PIPE_SETTLE = 6;
    localparam int unsigned HOLD_CYCLES = 80;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_dal_in               i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_dal_out              o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    daily_actuation_lockout dut (.*);

    always #6 i_clk = ~i_clk;

    // Gate model: configuration and day / grant bookkeeping
    logic [7:0]  lim_per_day = RST_MAX_PER_DAY;
    logic [15:0] gap_min = RST_MIN_GAP_MINUTES;
    logic [15:0] batt_floor = RST_BATTERY_MIN_MV;
    logic [15:0] cur_day = '0;
    logic [7:0]  grant_cnt = '0;
    logic        ever_granted = 1'b0;
    logic [31:0] last_grant_s = '0;

    t_dal_out    verdicts_due[$];
    t_dal_out    want;
    int unsigned bad = 0;
    int unsigned cycle_cnt = 0;

    // Sender pacing and receiver stall control
    logic        pace_on = 1'b0;
    int unsigned burst_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_tick = 0;
    int unsigned hold_left = 0;
    logic        hold_req = 1'b0;
    logic [31:0] clock_now = '0;

    function automatic logic [31:0] minutes_gone(input logic [31:0] now);
        if (!ever_granted)
            return '1;
        if (now <= last_grant_s)
            return '0;
        return (now - last_grant_s) / 32'd60;
    endfunction

    function automatic t_dal_out judge_request(input t_dal_in x);
        logic [31:0] day32;
        logic [2:0]  v;
        t_dal_out    r;
        day32 = x.now_seconds / 32'd86400;
        if (day32[15:0] != cur_day) begin
            cur_day = day32[15:0];
            grant_cnt = '0;
        end
        if (x.req_type == REQ_QUERY)
            v = V_QUERY;
        else if (x.sensor_err)
            v = V_SENSOR;
        else if (!x.soil_ok)
            v = V_SOIL;
        else if (x.battery_mv < batt_floor)
            v = V_BATTERY;
        else if (grant_cnt >= lim_per_day)
            v = V_LIMIT;
        else if (minutes_gone(x.now_seconds) < {16'd0, gap_min})
            v = V_SOON;
        else begin
            v = V_GRANTED;
            grant_cnt = grant_cnt + 8'd1;
            ever_granted = 1'b1;
            last_grant_s = x.now_seconds;
        end
        r.verdict = v;
        r.count_today = grant_cnt;
        r.minutes_since = minutes_gone(x.now_seconds);
        return r;
    endfunction

    // Predict on acceptance, then check whatever result leaves this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                verdicts_due.push_back(judge_request(i_in_data));
            if (o_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    bad++;
                    if (bad <= 10)
                        $display("unexpected result: verdict %0d count %0d minutes %0h",
                                 o_out_data.verdict, o_out_data.count_today,
                                 o_out_data.minutes_since);
                end else begin
                    want = verdicts_due.pop_front();
                    if (want.verdict !== o_out_data.verdict
                            || want.count_today !== o_out_data.count_today
                            || want.minutes_since !== o_out_data.minutes_since) begin
                        bad++;
                        if (bad <= 10)
                            $display({"mismatch: verdict exp %0d got %0d, count exp %0d got %0d,",
                                      " minutes exp %0h got %0h"},
                                     want.verdict, o_out_data.verdict,
                                     want.count_today, o_out_data.count_today,
                                     want.minutes_since, o_out_data.minutes_since);
                    end
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    always @(negedge i_clk) begin
        stall_tick++;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= (stall_tick[3:2] == 2'b11);
                default: i_out_stall <= ($urandom_range(0, 2) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("[daily_actuation_lockout] ERROR");
            $finish;
        end
    end

    function automatic t_dal_in mk(input logic rq, input logic [31:0] t, input logic f,
                                   input logic s, input logic [15:0] b);
        t_dal_in x;
        x.req_type = rq;
        x.now_seconds = t;
        x.sensor_err = f;
        x.soil_ok = s;
        x.battery_mv = b;
        return x;
    endfunction

    // Mostly small forward steps so gaps and daily limits bite; some day jumps,
    // some steps back in time and some arbitrary times
    function automatic t_dal_in rand_item();
        t_dal_in     x;
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 65)
            clock_now += $urandom_range(0, 5400);
        else if (k < 78)
            clock_now += $urandom_range(0, 90);
        else if (k < 87)
            clock_now += $urandom_range(20000, 90000);
        else if (k < 94)
            clock_now -= $urandom_range(0, 7200);
        else
            clock_now = $urandom();
        x.req_type = ($urandom_range(0, 9) < 8) ? REQ_SPRAY : REQ_QUERY;
        x.now_seconds = clock_now;
        x.sensor_err = ($urandom_range(0, 11) == 0);
        x.soil_ok = ($urandom_range(0, 11) != 0);
        case ($urandom_range(0, 9))
            0: x.battery_mv = 16'($urandom_range(0, 65535));
            1: x.battery_mv = batt_floor - 16'd1;
            2: x.battery_mv = batt_floor;
            3: x.battery_mv = 16'hFFFF;
            default: x.battery_mv = 16'($urandom_range(batt_floor, 65535));
        endcase
        return x;
    endfunction

    task automatic send_item(input t_dal_in x);
        int unsigned g;
        if (pace_on && burst_left == 0) begin
            g = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            repeat (g) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= x;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_MAX_PER_DAY:     lim_per_day = val[7:0];
            CFG_MIN_GAP_MINUTES: gap_min = val;
            CFG_BATTERY_MIN_MV:  batt_floor = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(input logic [7:0] mx, input logic [15:0] gp,
                              input logic [15:0] bt);
        logic [7:0] junk;
        junk = 8'($urandom());
        settle();
        write_reg(CFG_MAX_PER_DAY, {junk, mx});
        write_reg(CFG_MIN_GAP_MINUTES, gp);
        write_reg(CFG_BATTERY_MIN_MV, bt);
    endtask

    task automatic test_directed();
        pace_on = 1'b0;
        stall_mode = 1;
        send_item(mk(REQ_QUERY, 32'd0, 1'b0, 1'b1, 16'd5000));
        // refusal priority: fault over soil over battery
        send_item(mk(REQ_SPRAY, 32'd10, 1'b1, 1'b0, 16'd0));
        send_item(mk(REQ_SPRAY, 32'd10, 1'b0, 1'b0, 16'd0));
        send_item(mk(REQ_SPRAY, 32'd10, 1'b0, 1'b1, 16'd3299));
        send_item(mk(REQ_SPRAY, 32'd1000, 1'b0, 1'b1, 16'd3300));
        send_item(mk(REQ_QUERY, 32'd1059, 1'b0, 1'b1, 16'd0));
        send_item(mk(REQ_QUERY, 32'd1060, 1'b0, 1'b1, 16'd0));
        // one minute short of the gap, then exactly on it
        send_item(mk(REQ_SPRAY, 32'd4599, 1'b0, 1'b1, 16'hFFFF));
        send_item(mk(REQ_SPRAY, 32'd4600, 1'b0, 1'b1, 16'hFFFF));
        send_item(mk(REQ_SPRAY, 32'd8200, 1'b0, 1'b1, 16'hFFFF));
        send_item(mk(REQ_SPRAY, 32'd20000, 1'b0, 1'b1, 16'hFFFF));
        // clock behind and level with the last grant
        send_item(mk(REQ_QUERY, 32'd500, 1'b0, 1'b1, 16'hFFFF));
        send_item(mk(REQ_QUERY, 32'd8200, 1'b0, 1'b1, 16'hFFFF));
        send_item(mk(REQ_SPRAY, 32'd86399, 1'b0, 1'b1, 16'hFFFF));
        // day roll-over clears the count
        send_item(mk(REQ_SPRAY, 32'd86400, 1'b0, 1'b1, 16'hFFFF));
        send_item(mk(REQ_SPRAY, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'hFFFF));
        send_item(mk(REQ_QUERY, 32'd0, 1'b1, 1'b0, 16'd0));
    endtask

    task automatic test_config_writes();
        stall_mode = 2;
        settle();
        // zero daily limit; upper data bits must be dropped
        write_reg(CFG_MAX_PER_DAY, 16'hAB00);
        send_item(mk(REQ_SPRAY, 32'd200000, 1'b0, 1'b1, 16'hFFFF));
        settle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_item(mk(REQ_SPRAY, 32'd200000, 1'b0, 1'b1, 16'hFFFF));
        settle();
        write_reg(CFG_MAX_PER_DAY, 16'hFFFF);
        write_reg(CFG_MIN_GAP_MINUTES, 16'h0000);
        write_reg(CFG_BATTERY_MIN_MV, 16'h0000);
        repeat (3) send_item(mk(REQ_SPRAY, 32'd200000, 1'b0, 1'b1, 16'd0));
        settle();
        write_reg(CFG_MIN_GAP_MINUTES, 16'hFFFF);
        write_reg(CFG_BATTERY_MIN_MV, 16'hFFFF);
        send_item(mk(REQ_SPRAY, 32'd200100, 1'b0, 1'b1, 16'hFFFE));
        send_item(mk(REQ_SPRAY, 32'd200100, 1'b0, 1'b1, 16'hFFFF));
        send_item(mk(REQ_SPRAY, 32'd4132100, 1'b0, 1'b1, 16'hFFFF));
    endtask

    task automatic test_backpressure();
        int n;
        set_limits(8'd4, 16'd10, 16'd3000);
        stall_mode = 0;
        pace_on = 1'b0;
        @(posedge i_clk);
        hold_req = 1'b1;
        for (n = 0; n < 30; n++)
            send_item(rand_item());
        settle();
        pace_on = 1'b1;
        stall_mode = 1;
        @(posedge i_clk);
        hold_req = 1'b1;
        for (n = 0; n < 30; n++)
            send_item(rand_item());
        settle();
    endtask

    task automatic test_random_phases();
        logic [7:0]  mx;
        logic [15:0] gp;
        logic [15:0] bt;
        int          p;
        int          n;
        for (p = 0; p < 7; p++) begin
            case (p)
                0: begin mx = RST_MAX_PER_DAY; gp = RST_MIN_GAP_MINUTES;
                         bt = RST_BATTERY_MIN_MV; end
                1: begin mx = 8'd0;   gp = 16'd0;      bt = 16'd0;      end
                2: begin mx = 8'hFF;  gp = 16'd0;      bt = 16'd0;      end
                3: begin mx = 8'd1;   gp = 16'hFFFF;   bt = 16'hFFFF;   end
                4: begin mx = 8'($urandom_range(1, 6)); gp = 16'($urandom_range(0, 120));
                         bt = 16'($urandom_range(2000, 4000)); end
                5: begin mx = 8'($urandom()); gp = 16'($urandom());
                         bt = 16'($urandom()); end
                default: begin mx = 8'hFF; gp = 16'd1; bt = RST_BATTERY_MIN_MV; end
            endcase
            set_limits(mx, gp, bt);
            clock_now = $urandom();
            for (n = 0; n < 200; n++) begin
                // vary idling every so often, sometimes with none at all
                if (n % 50 == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    pace_on = ($urandom_range(0, 3) != 0);
                end
                send_item(rand_item());
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config_writes();
        test_backpressure();
        test_random_phases();
        settle();
        if (bad == 0 && verdicts_due.size() == 0)
            $display("[daily_actuation_lockout] OK");
        else
            $display("[daily_actuation_lockout] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dal_pkg.sv
rtl/core/daily_actuation_lockout.sv
bench/tb.sv
